/* rtl/dlsm_pkg.sv */
// Package for the dual LFSR stream masker: shared widths, seeds, register indexes
// and the control bundle passed from the sequencer to the keystream generator.
// No dependencies.
package dlsm_pkg;

   localparam int unsigned SHORT_BITS = 19;
   localparam int unsigned SHORT_TAP  = 6;
   localparam int unsigned LONG_BITS  = 118;
   localparam int unsigned LONG_TAP   = 84;
   localparam int unsigned BYTE_BITS  = 8;
   localparam int unsigned COUNT_BITS = 8;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 19;

   localparam logic [SHORT_BITS-1:0] SEED_SHORT_RESET = 19'h43E8B;
   localparam logic [COUNT_BITS-1:0] BITS_PER_BYTE_RESET = 8'd8;

   localparam logic [LONG_BITS-1:0] LONG_SEED =
      118'b1111111001110010011000011001010100010010000101111111110101001010000000110001101111111011111011110010010000101111001101;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEED_SHORT    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BITS_PER_BYTE = 2'd1;

   typedef struct packed {
      logic load;
      logic step;
   } kg_ctrl_type;

endpackage

/* rtl/dlsm_keygen.sv */
// Keystream generator: the 19-bit and 118-bit shift registers and their combined
// feedback bit, advanced one step per cycle on request. Depends on dlsm_pkg.
module dlsm_keygen (
   input  logic                               clock,
   input  logic                               reset,
   input  dlsm_pkg::kg_ctrl_type              ctrl,
   input  logic [dlsm_pkg::SHORT_BITS-1:0]    seed_short,
   output logic                               key_bit
);

   logic [dlsm_pkg::SHORT_BITS-1:0] short_ff, short_in;
   logic [dlsm_pkg::LONG_BITS-1:0]  long_ff, long_in;
   logic fb_short, fb_long;

   assign fb_short = short_ff[0] ^ short_ff[dlsm_pkg::SHORT_TAP];
   assign fb_long  = long_ff[dlsm_pkg::LONG_BITS-1] ^ long_ff[dlsm_pkg::LONG_TAP];
   assign key_bit  = fb_short ^ fb_long;

   always_comb begin
      short_in = short_ff;
      long_in  = long_ff;
      if (ctrl.load) begin
         short_in = seed_short;
         long_in  = dlsm_pkg::LONG_SEED;
      end else if (ctrl.step) begin
         short_in = {fb_short, short_ff[dlsm_pkg::SHORT_BITS-1:1]};
         long_in  = {fb_long, long_ff[dlsm_pkg::LONG_BITS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= dlsm_pkg::SEED_SHORT_RESET;
         long_ff  <= dlsm_pkg::LONG_SEED;
      end else begin
         short_ff <= short_in;
         long_ff  <= long_in;
      end
   end

endmodule

/* rtl/dlsm_seq.sv */
// Sequencer: accepts a transaction, runs the generator for the configured number
// of steps, gathers the mask and holds the result register. Depends on dlsm_pkg.
module dlsm_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dlsm_pkg::BYTE_BITS-1:0]     req_data_byte,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [dlsm_pkg::BYTE_BITS-1:0]     rsp_out_byte,
   input  logic [dlsm_pkg::COUNT_BITS-1:0]    bits_per_byte,
   input  logic                               key_bit,
   output dlsm_pkg::kg_ctrl_type              ctrl
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                         state_ff;
   logic [dlsm_pkg::COUNT_BITS-1:0]   count_ff;
   logic [dlsm_pkg::BYTE_BITS-1:0]    data_ff;
   logic [dlsm_pkg::BYTE_BITS-1:0]    acc_ff;
   logic [dlsm_pkg::BYTE_BITS-1:0]    acc_in;
   logic                              rsp_valid_ff;
   logic [dlsm_pkg::BYTE_BITS-1:0]    rsp_out_byte_ff;
   logic                              slot_free;
   logic                              accept;
   logic                              done;

   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign done         = (state_ff == ST_RUN) && (count_ff == '0 || count_ff == 8'd1)
                         && slot_free;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign acc_in       = {acc_ff[dlsm_pkg::BYTE_BITS-2:0], key_bit};

   always_comb begin
      ctrl.load = accept && req_restart;
      ctrl.step = 1'b0;
      if (state_ff == ST_RUN && count_ff != '0) begin
         ctrl.step = (count_ff != 8'd1) || slot_free;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  data_ff  <= req_data_byte;
                  count_ff <= bits_per_byte;
                  acc_ff   <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (count_ff == '0) begin
                  if (slot_free) begin
                     rsp_out_byte_ff <= data_ff;
                     state_ff        <= ST_IDLE;
                  end
               end else if (count_ff == 8'd1) begin
                  if (slot_free) begin
                     rsp_out_byte_ff <= data_ff ^ acc_in;
                     state_ff        <= ST_IDLE;
                  end
               end else begin
                  acc_ff   <= acc_in;
                  count_ff <= count_ff - 8'd1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/dual_lfsr_stream_masker_core.sv */
// Dual LFSR stream masker: XORs each data byte with a keystream byte taken from
// two combined shift registers. Masking and unmasking are the same operation.
// Depends on dlsm_pkg, dlsm_seq and dlsm_keygen.
//
// Channels: req_ carries one byte and a restart flag per transaction, rsp_ returns
// the masked byte, csr_ writes seed_short (index 0) and bits_per_byte (index 1).
// Writes to other indexes are ignored; csr_ready is always high.
// A restart reloads both shift registers from their seeds before the byte.
// After acceptance the block runs one generator step per cycle through the single
// keystream unit; the result is registered at the edge of the last step (or, for a
// count of zero, with no step), and the block is ready again from that same edge,
// so it takes no new byte until the result of the one before is registered.
// The output register lets a result wait while the next byte is accepted and
// stepped; only the final step, or the finish for a count of zero, waits until
// the previous result is taken.
// Reset, synchronous and active high, restores the register defaults and loads
// both shift registers from their seeds; no clearing pass is needed.
module dual_lfsr_stream_masker_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [dlsm_pkg::BYTE_BITS-1:0]         req_data_byte,
   input  logic                                   req_restart,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [dlsm_pkg::BYTE_BITS-1:0]         rsp_out_byte,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dlsm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [dlsm_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   logic [dlsm_pkg::SHORT_BITS-1:0] seed_short_ff;
   logic [dlsm_pkg::COUNT_BITS-1:0] bits_per_byte_ff;
   dlsm_pkg::kg_ctrl_type           ctrl;
   logic                            key_bit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_short_ff    <= dlsm_pkg::SEED_SHORT_RESET;
         bits_per_byte_ff <= dlsm_pkg::BITS_PER_BYTE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dlsm_pkg::CSR_SEED_SHORT: begin
               seed_short_ff <= csr_data[dlsm_pkg::SHORT_BITS-1:0];
            end
            dlsm_pkg::CSR_BITS_PER_BYTE: begin
               bits_per_byte_ff <= csr_data[dlsm_pkg::COUNT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   dlsm_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .bits_per_byte (bits_per_byte_ff),
      .key_bit       (key_bit),
      .ctrl          (ctrl)
   );

   dlsm_keygen u_keygen (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .seed_short (seed_short_ff),
      .key_bit    (key_bit)
   );

endmodule

/* rtl/dlsm_checker.sv */
// Port-level checks for the dual LFSR stream masker, attached to the top level
// by the bind statement at the end. Depends on dlsm_pkg.
module dlsm_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [dlsm_pkg::BYTE_BITS-1:0]         rsp_out_byte
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled result changed or dropped");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready again directly after a transaction was accepted");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared in the cycle after acceptance");

endmodule

bind dual_lfsr_stream_masker_core dlsm_checker u_dlsm_checker (.*);
